@@ sv/cfp_pkg.sv @@
package cfp_pkg;

	localparam logic [7:0] BYTE_START = 8'hFF;
	localparam logic [7:0] BYTE_END   = 8'hFE;
	localparam logic [7:0] MODE_LOW   = 8'hF9;

	typedef enum logic [2:0] {
		PH_START   = 3'd0,
		PH_MODE    = 3'd1,
		PH_LENGTH  = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_END     = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD  = 2'd0,
		KIND_COMPLETE = 2'd1,
		KIND_ERROR    = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] payload_byte;
		logic [7:0] payload_index;
		logic [7:0] frame_mode;
		logic [7:0] frame_length;
	} result_t;

	typedef struct packed {
		logic    valid;
		result_t data;
	} result_flow_t;

endpackage

@@ sv/command_frame_parser_unit.sv @@
// Channel  Dir  Handshake          Content
// s_       in   s_tvalid/s_tready  tdata: rx_byte; tlast: last_byte
// m_       out  m_tvalid/m_tready  tdata: payload_byte, payload_index, frame_mode,
//                                  frame_length; tuser: kind
//
// One byte is accepted per cycle while s_tready is high; its result, if any, is
// registered. The parser state machine decides each byte; an output register and
// a one-entry skid register separate it from the output channel.
// Reset is asynchronous and returns the parser to hunting for a start byte.
// s_tready is low only while the skid register is full, so while the output
// stalls the skid register takes one more transaction before the input stalls.
module command_frame_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] rx_byte
	input  logic        s_tlast,  // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [7:0] payload_byte, [15:8] payload_index,
	                              // [23:16] frame_mode, [31:24] frame_length
	output logic [1:0]  m_tuser   // [1:0] kind
);
	import cfp_pkg::*;

	result_flow_t res;
	result_t      out_q, skid_q;
	logic         out_valid_q, skid_valid_q;
	logic         accept, load_out;

	assign s_tready = !skid_valid_q;
	assign accept   = s_tvalid && s_tready;
	assign load_out = !out_valid_q || m_tready;

	cfp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.rx_byte   (s_tdata),
		.last_byte (s_tlast),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q  <= skid_valid_q || res.valid;
			skid_valid_q <= 1'b0;
		end else if (res.valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= skid_valid_q ? skid_q : res.data;
		end else if (res.valid) begin
			skid_q <= res.data;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.kind;
	assign m_tdata  = {out_q.frame_length, out_q.frame_mode,
	                   out_q.payload_index, out_q.payload_byte};

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("Skid register holds a transaction while the output is empty.");

	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && !m_tready |=> skid_valid_q && $stable(skid_q))
		else $error("Skid register lost a transaction during a stall.");

endmodule

@@ sv/cfp_parser.sv @@
module cfp_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [7:0]           rx_byte,
	input  logic                 last_byte,
	output cfp_pkg::result_flow_t res
);
	import cfp_pkg::*;

	phase_t     phase_q, phase_d;
	logic [7:0] held_mode_q, held_mode_d;
	logic [7:0] held_length_q, held_length_d;
	logic [7:0] byte_count_q, byte_count_d;
	logic [7:0] count_inc;

	assign count_inc = byte_count_q + 8'd1;

	always_comb begin
		phase_d       = phase_q;
		held_mode_d   = held_mode_q;
		held_length_d = held_length_q;
		byte_count_d  = byte_count_q;
		unique case (phase_q)
			PH_MODE: begin
				if (rx_byte >= MODE_LOW) begin
					held_mode_d = rx_byte;
					phase_d     = PH_LENGTH;
				end else begin
					phase_d = PH_START;
				end
			end
			PH_LENGTH: begin
				held_length_d = rx_byte;
				byte_count_d  = 8'd0;
				phase_d       = (rx_byte == 8'd0) ? PH_END : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				byte_count_d = count_inc;
				if (count_inc == held_length_q) begin
					phase_d = PH_END;
				end
			end
			PH_END: begin
				phase_d = PH_START;
			end
			default: begin
				phase_d = (rx_byte == BYTE_START) ? PH_MODE : PH_START;
			end
		endcase
		if (last_byte) begin
			phase_d       = PH_START;
			held_mode_d   = 8'd0;
			held_length_d = 8'd0;
			byte_count_d  = 8'd0;
		end
	end

	always_comb begin
		res = '0;
		res.data.kind = KIND_ERROR;
		unique case (phase_q)
			PH_MODE: begin
				res.valid = accept && (rx_byte < MODE_LOW);
			end
			PH_LENGTH: begin
				res.valid = 1'b0;
			end
			PH_PAYLOAD: begin
				res.valid              = accept;
				res.data.kind          = KIND_PAYLOAD;
				res.data.payload_byte  = rx_byte;
				res.data.payload_index = byte_count_q;
			end
			PH_END: begin
				res.valid = accept;
				if (rx_byte == BYTE_END) begin
					res.data.kind         = KIND_COMPLETE;
					res.data.frame_mode   = held_mode_q;
					res.data.frame_length = held_length_q;
				end
			end
			default: begin
				res.valid = accept && (rx_byte != BYTE_START);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_START;
			held_mode_q   <= 8'd0;
			held_length_q <= 8'd0;
			byte_count_q  <= 8'd0;
		end else if (accept) begin
			phase_q       <= phase_d;
			held_mode_q   <= held_mode_d;
			held_length_q <= held_length_d;
			byte_count_q  <= byte_count_d;
		end
	end

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_byte |=> phase_q == PH_START && byte_count_q == 8'd0)
		else $error("Parser state not cleared after a last byte.");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> byte_count_q < held_length_q)
		else $error("Payload count has reached the frame length.");

endmodule

@@ tb/sv/tb_command_frame_parser_unit.sv @@
module tb_command_frame_parser_unit;

	import cfp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 20;
	localparam int MAX_WAIT    = 10;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} rx_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;  // [7:0] rx_byte
	logic        s_tlast = 1'b0;   // last_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;  // [7:0] payload_byte, [15:8] payload_index,
	                       // [23:16] frame_mode, [31:24] frame_length
	logic [1:0]  m_tuser;  // [1:0] kind

	rx_item_t rx_bytes_pending[$];
	result_t  frame_results_due[$];

	phase_t     frame_phase = PH_START;
	logic [7:0] held_mode = 8'h00;
	logic [7:0] held_length = 8'h00;
	logic [7:0] payload_count = 8'h00;

	int       error_count = 0;
	int       cycle_count = 0;
	int       in_wait = 0;
	int       out_wait = 0;
	bit       in_burst = 1'b0;
	bit       out_burst = 1'b0;
	rx_item_t next_item;
	result_t  due;

	command_frame_parser_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int draw_wait(input bit burst);
		return burst ? 0 : $urandom_range(0, MAX_WAIT);
	endfunction

	function automatic void check_field(input string name, input logic [7:0] exp_val,
	                                    input logic [7:0] act_val);
		if (exp_val !== act_val) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val,
			         act_val);
			error_count++;
		end
	endfunction

	task automatic parse_rx_byte(input logic [7:0] b, input logic last);
		result_t r;
		bit      emit;
		r = '0;
		emit = 1'b0;
		case (frame_phase)
			PH_MODE: begin
				if (b >= MODE_LOW) begin
					held_mode = b;
					frame_phase = PH_LENGTH;
				end else begin
					r.kind = KIND_ERROR;
					emit = 1'b1;
					frame_phase = PH_START;
				end
			end
			PH_LENGTH: begin
				held_length = b;
				payload_count = 8'h00;
				frame_phase = (b == 8'h00) ? PH_END : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				r.kind = KIND_PAYLOAD;
				r.payload_byte = b;
				r.payload_index = payload_count;
				emit = 1'b1;
				payload_count = payload_count + 8'd1;
				if (payload_count == held_length)
					frame_phase = PH_END;
			end
			PH_END: begin
				if (b == BYTE_END) begin
					r.kind = KIND_COMPLETE;
					r.frame_mode = held_mode;
					r.frame_length = held_length;
				end else begin
					r.kind = KIND_ERROR;
				end
				emit = 1'b1;
				frame_phase = PH_START;
			end
			default: begin
				if (b == BYTE_START) begin
					frame_phase = PH_MODE;
				end else begin
					r.kind = KIND_ERROR;
					emit = 1'b1;
					frame_phase = PH_START;
				end
			end
		endcase
		if (emit)
			frame_results_due.push_back(r);
		if (last) begin
			frame_phase = PH_START;
			held_mode = 8'h00;
			held_length = 8'h00;
			payload_count = 8'h00;
		end
	endtask

	task automatic push_rx(input logic [7:0] b, input logic last);
		rx_item_t it;
		it.data = b;
		it.last = last;
		rx_bytes_pending.push_back(it);
	endtask

	// A negative cut position sends the whole frame; otherwise the frame stops
	// at that byte, which carries the last-of-buffer flag.
	task automatic push_frame(input logic [7:0] mode, input int len,
	                          input logic [7:0] end_byte, input int cut);
		int         pos;
		logic [7:0] b;
		for (pos = 0; pos <= len + 3; pos++) begin
			if (pos == 0)
				b = BYTE_START;
			else if (pos == 1)
				b = mode;
			else if (pos == 2)
				b = len[7:0];
			else if (pos == len + 3)
				b = end_byte;
			else
				b = 8'($urandom_range(0, 255));
			push_rx(b, pos == cut);
			if (pos == cut)
				break;
		end
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("command_frame_parser_unit test failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				parse_rx_byte(s_tdata, s_tlast);
			if (!s_tvalid || s_tready) begin
				if (in_wait > 0) begin
					in_wait--;
					s_tvalid <= 1'b0;
				end else if (rx_bytes_pending.size() > 0) begin
					next_item = rx_bytes_pending.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= next_item.data;
					s_tlast <= next_item.last;
					if ($urandom_range(0, 47) == 0)
						in_burst = !in_burst;
					in_wait = draw_wait(in_burst);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (frame_results_due.size() == 0) begin
					$display("%0t: unexpected transaction, expected none, actual kind %0d data %h",
					         $time, m_tuser, m_tdata);
					error_count++;
				end else begin
					due = frame_results_due.pop_front();
					check_field("kind", {6'd0, due.kind}, {6'd0, m_tuser});
					check_field("payload_byte", due.payload_byte, m_tdata[7:0]);
					check_field("payload_index", due.payload_index, m_tdata[15:8]);
					check_field("frame_mode", due.frame_mode, m_tdata[23:16]);
					check_field("frame_length", due.frame_length, m_tdata[31:24]);
				end
				if ($urandom_range(0, 47) == 0)
					out_burst = !out_burst;
				out_wait = draw_wait(out_burst);
			end
			if (out_wait > 0) begin
				out_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		int         kind_draw;
		int         len;
		int         n;
		logic [7:0] e;

		push_rx(8'hFF, 1'b0);
		push_rx(8'hF9, 1'b0);
		push_rx(8'h00, 1'b0);
		push_rx(8'hFE, 1'b0);
		push_rx(8'hFF, 1'b0);
		push_rx(8'hFF, 1'b0);
		push_rx(8'h02, 1'b0);
		push_rx(8'h00, 1'b0);
		push_rx(8'hFF, 1'b0);
		push_rx(8'hFE, 1'b0);
		push_rx(8'h00, 1'b0);
		push_rx(8'hFE, 1'b0);
		push_rx(8'hFF, 1'b0);
		push_rx(8'hF8, 1'b0);
		push_rx(8'hFF, 1'b0);
		push_rx(8'hFA, 1'b0);
		push_rx(8'h00, 1'b0);
		push_rx(8'hFD, 1'b0);
		push_rx(8'hFF, 1'b0);
		push_rx(8'hFB, 1'b0);
		push_rx(8'h03, 1'b0);
		push_rx(8'h11, 1'b1);
		push_rx(8'h22, 1'b0);
		push_rx(8'hFF, 1'b1);
		push_rx(8'hF9, 1'b0);
		push_frame(8'hFC, 255, BYTE_END, -1);

		while (rx_bytes_pending.size() < 850) begin
			kind_draw = $urandom_range(0, 99);
			if (kind_draw < 70) begin
				len = ($urandom_range(0, 49) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
				push_frame(8'($urandom_range(8'hF9, 8'hFF)), len, BYTE_END,
				           ($urandom_range(0, 7) == 0) ? $urandom_range(0, len + 3) : -1);
			end else if (kind_draw < 78) begin
				push_rx(BYTE_START, 1'b0);
				push_rx(8'($urandom_range(0, 8'hF8)), $urandom_range(0, 3) == 0);
			end else if (kind_draw < 88) begin
				e = 8'($urandom_range(0, 254));
				if (e == BYTE_END)
					e = 8'hFF;
				push_frame(8'($urandom_range(8'hF9, 8'hFF)), $urandom_range(0, 4), e, -1);
			end else begin
				for (n = $urandom_range(1, 4); n > 0; n--)
					push_rx(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		@(posedge clk);
		while (rx_bytes_pending.size() > 0 || s_tvalid || frame_results_due.size() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("command_frame_parser_unit test passed");
		else
			$display("command_frame_parser_unit test failed");
		$finish;
	end

endmodule
